@@ src/pss_pkg.sv @@
// Shared types, constants and codes for the photoabsorption shell select block.
// Used by pss_front, pss_back and photoabsorption_shell_select.
package pss_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam int DIN_W  = 160;
	localparam int DOUT_W = 56;

	localparam logic [23:0] E_K   = 24'd470784;
	localparam logic [23:0] E_L1  = 24'd38067;
	localparam logic [23:0] E_L23 = 24'd25395;
	localparam logic [23:0] E_M   = 24'd2918;
	localparam logic [15:0] K_SELECT_MAX = 16'd60293;

	localparam logic [5:0]  M_HOLE_MUL = 6'd57;
	localparam logic [15:0] RECIP5     = 16'd52429;

	localparam logic REG_BAND_GAP   = 1'b0;
	localparam logic REG_TABLE_ROWS = 1'b1;

	typedef enum logic [2:0] {
		SH_K  = 3'd0,
		SH_L1 = 3'd1,
		SH_L2 = 3'd2,
		SH_L3 = 3'd3,
		SH_M  = 3'd4
	} shell_t;

	typedef enum logic [2:0] {
		CLS_LOAD,
		CLS_KL1,
		CLS_WALK,
		CLS_MBND,
		CLS_MLOW
	} class_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_WALK,
		BK_HOLE1,
		BK_HOLE2,
		BK_LOW,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [15:0] band_gap;
		logic [8:0]  table_rows;
	} cfg_t;

	typedef struct packed {
		logic [23:0] energy;
		logic [16:0] prob_m;
		logic [16:0] prob_l1;
		logic [16:0] prob_l2;
		logic [16:0] prob_l3;
	} row_t;

	typedef struct packed {
		class_t      cls;
		logic [7:0]  row_index;
		row_t        row;
		logic [23:0] lost_energy;
		logic [15:0] rand_select;
		logic [15:0] rand_hole;
	} item_t;

endpackage

@@ src/pss_front.sv @@
// Front end: unpacks input beats, classifies them by request kind and energy band,
// and holds them in a short queue for the back end. Depends on pss_pkg.
module pss_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// row_index, row_energy, prob_m, prob_l1, prob_l2, prob_l3, lost_energy,
	// rand_select, rand_hole
	input  logic [pss_pkg::DIN_W-1:0] s_tdata,
	// req_type
	input  logic                      s_tuser,
	output logic                      q_valid,
	output pss_pkg::item_t            q_item,
	input  logic                      q_pop
);
	import pss_pkg::*;

	item_t             in_item;
	item_t             queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	always_comb begin
		in_item.row_index      = s_tdata[7:0];
		in_item.row.energy     = s_tdata[31:8];
		in_item.row.prob_m     = s_tdata[48:32];
		in_item.row.prob_l1    = s_tdata[65:49];
		in_item.row.prob_l2    = s_tdata[82:66];
		in_item.row.prob_l3    = s_tdata[99:83];
		in_item.lost_energy    = s_tdata[123:100];
		in_item.rand_select    = s_tdata[139:124];
		in_item.rand_hole      = s_tdata[155:140];
		priority if (!s_tuser) begin
			in_item.cls = CLS_LOAD;
		end else if (s_tdata[123:100] > E_K) begin
			in_item.cls = CLS_KL1;
		end else if (s_tdata[123:100] > E_L23) begin
			in_item.cls = CLS_WALK;
		end else if (s_tdata[123:100] > E_M) begin
			in_item.cls = CLS_MBND;
		end else begin
			in_item.cls = CLS_MLOW;
		end
	end

	assign s_tready = (count_q < QCNT_W'(QDEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/pss_back.sv @@
// Back end: row table memory, binary search, shell walk, hole energy and the
// output register. Depends on pss_pkg.
module pss_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pss_pkg::cfg_t              cfg,
	input  logic                       q_valid,
	input  pss_pkg::item_t             q_item,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// shell, secondary_energy, deposited_energy
	output logic [pss_pkg::DOUT_W-1:0] m_tdata,
	// prob_mismatch
	output logic                       m_tuser
);
	import pss_pkg::*;

	back_state_t      state_q;
	back_state_t      state_n;

	row_t             mem [TABLE_DEPTH];
	row_t             rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             mem_we;

	logic [23:0]      e_q;
	logic [15:0]      rs_q;
	logic [15:0]      rh_q;
	logic             load_q;
	shell_t           shell_q;
	logic             mism_q;
	logic [23:0]      hole_q;
	logic [13:0]      y_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [IDX_W-1:0] mid_q;

	logic [CNT_W-1:0] n_rows;
	logic [IDX_W-1:0] mid0;
	logic             cmp;
	logic [CNT_W-1:0] lo_n;
	logic [CNT_W-1:0] hi_n;
	logic [CNT_W:0]   sum_n;
	logic [IDX_W-1:0] mid_n;
	logic [IDX_W-1:0] row_n;

	logic [18:0]      c1, c2, c3, c4;
	shell_t           walk_shell;
	logic             walk_mism;

	logic [21:0]      prod1;
	logic [29:0]      prod2;
	logic [23:0]      low_diff;
	logic [27:0]      prod3;
	logic [23:0]      binding;
	logic [25:0]      sec_full;
	logic             out_load;
	logic             m_tvalid_q;
	logic [DOUT_W-1:0] m_tdata_q;
	logic             m_tuser_q;

	always_comb begin
		if (cfg.table_rows == '0) begin
			n_rows = CNT_W'(1);
		end else if (32'(cfg.table_rows) > TABLE_DEPTH) begin
			n_rows = CNT_W'(TABLE_DEPTH);
		end else begin
			n_rows = CNT_W'(cfg.table_rows);
		end
	end

	assign mid0    = IDX_W'(n_rows >> 1);
	assign cmp     = (rd_q.energy <= e_q);
	assign lo_n    = cmp ? CNT_W'(mid_q) + 1'b1 : lo_q;
	assign hi_n    = cmp ? hi_q : CNT_W'(mid_q);
	assign sum_n   = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n   = IDX_W'(sum_n >> 1);
	assign row_n   = (lo_n == '0) ? '0 : IDX_W'(lo_n - 1'b1);
	assign wr_addr = IDX_W'(q_item.row_index);

	always_comb begin
		c1 = 19'(rd_q.prob_m);
		c2 = c1 + 19'(rd_q.prob_l1);
		c3 = c2 + 19'(rd_q.prob_l2);
		c4 = c3 + 19'(rd_q.prob_l3);
		walk_mism = 1'b0;
		priority if (19'(rs_q) <= c1) begin
			walk_shell = SH_M;
		end else if (19'(rs_q) <= c2) begin
			walk_shell = SH_L1;
		end else if (19'(rs_q) <= c3) begin
			walk_shell = SH_L2;
		end else if (19'(rs_q) <= c4) begin
			walk_shell = SH_L3;
		end else begin
			walk_shell = SH_M;
			walk_mism  = 1'b1;
		end
	end

	assign prod1    = 22'(rh_q) * 22'(M_HOLE_MUL);
	assign prod2    = 30'(y_q) * 30'(RECIP5);
	assign low_diff = e_q - 24'(cfg.band_gap);
	assign prod3    = 28'(low_diff[11:0]) * 28'(rh_q);

	always_comb begin
		unique case (shell_q)
			SH_K:        binding = E_K;
			SH_L1:       binding = E_L1;
			SH_L2, SH_L3: binding = E_L23;
			default:     binding = '0;
		endcase
	end

	assign sec_full = load_q ? '0 :
		{2'b00, e_q} - {2'b00, hole_q} - {2'b00, binding} - 26'(cfg.band_gap);

	always_comb begin
		state_n  = state_q;
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		rd_addr  = mid_q;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_item.cls)
						CLS_LOAD: begin
							mem_we  = (32'(q_item.row_index) < TABLE_DEPTH);
							state_n = BK_DONE;
						end
						CLS_KL1:  state_n = BK_DONE;
						CLS_WALK: begin
							rd_addr = mid0;
							state_n = BK_SEARCH;
						end
						CLS_MBND: state_n = BK_HOLE1;
						CLS_MLOW: state_n = BK_LOW;
						default:  state_n = BK_DONE;
					endcase
				end
			end
			BK_SEARCH: begin
				if (lo_n < hi_n) begin
					rd_addr = mid_n;
				end else begin
					rd_addr = row_n;
					state_n = BK_WALK;
				end
			end
			BK_WALK:  state_n = (walk_shell == SH_M) ? BK_HOLE1 : BK_DONE;
			BK_HOLE1: state_n = BK_HOLE2;
			BK_HOLE2: state_n = BK_DONE;
			BK_LOW:   state_n = BK_DONE;
			BK_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_n  = BK_IDLE;
				end
			end
			default:  state_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= q_item.row;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					e_q    <= q_item.lost_energy;
					rs_q   <= q_item.rand_select;
					rh_q   <= q_item.rand_hole;
					load_q <= (q_item.cls == CLS_LOAD);
					hole_q <= '0;
					mism_q <= 1'b0;
					lo_q   <= '0;
					hi_q   <= n_rows;
					mid_q  <= mid0;
					if (q_item.cls == CLS_LOAD) begin
						shell_q <= SH_K;
					end else if (q_item.cls == CLS_KL1) begin
						shell_q <= (q_item.rand_select <= K_SELECT_MAX) ? SH_K : SH_L1;
					end else begin
						shell_q <= SH_M;
					end
				end
			end
			BK_SEARCH: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
			end
			BK_WALK: begin
				shell_q <= walk_shell;
				mism_q  <= walk_mism;
			end
			BK_HOLE1: y_q <= prod1[21:8];
			BK_HOLE2: hole_q <= 24'(prod2[29:18]);
			BK_LOW:   hole_q <= (e_q > 24'(cfg.band_gap)) ? 24'(prod3[27:16]) : '0;
			default: begin
				hole_q <= hole_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {4'b0000, hole_q, sec_full[24:0], shell_q};
			m_tuser_q <= mism_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ src/photoabsorption_shell_select.sv @@
// Path, input beat to result beat: queue, back-end states, output register. Loads and K/L1 events
// go from IDLE to DONE, the lowest band via LOW, the middle M band via HOLE1 and HOLE2; the table
// band searches in SEARCH, at most ceil(log2(n + 1)) steps of one table read each, n = table_rows
// clamped to 1..256, then WALK, and HOLE1 and HOLE2 if M is drawn; DONE waits for the output stage.
// One item at a time in the back end; a two-entry queue and an output register decouple the ports.
// Reset clears queue, control state and registers (band_gap 0, table_rows 1); table rows are not.
module photoabsorption_shell_select (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// row_index, row_energy, prob_m, prob_l1, prob_l2, prob_l3, lost_energy,
	// rand_select, rand_hole
	input  logic [pss_pkg::DIN_W-1:0]  s_tdata,
	// req_type
	input  logic                       s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// shell, secondary_energy, deposited_energy
	output logic [pss_pkg::DOUT_W-1:0] m_tdata,
	// prob_mismatch
	output logic                       m_tuser,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [15:0]                cfg_data
);
	import pss_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_gap   <= '0;
			cfg_q.table_rows <= 9'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAND_GAP:   cfg_q.band_gap   <= cfg_data;
				REG_TABLE_ROWS: cfg_q.table_rows <= cfg_data[8:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	pss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	pss_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_shell_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= SH_M))
		else $error("shell code out of range");

	a_mismatch_m: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[2:0] == SH_M))
		else $error("probability mismatch without M shell");

	a_hole_m: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[51:28] != '0)) |-> (m_tdata[2:0] == SH_M))
		else $error("deposited energy on a non-M shell");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty queue");

endmodule
